>>> design/jmp_pkg.sv
// Shared types and constants for the joint motion profiler.
`timescale 1ns / 1ps
package jmp_pkg;
    localparam int JOINT_COUNT_DEF = 3;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int EXT_BITS = 16;
    localparam int ACCEL_W = 20;
    localparam int SPEED_W = 15;
    localparam int CFG_W = 20;
    localparam int REPORTED = 3;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [0:0] CFG_MAX_ACCEL = 1'b0;
    localparam logic [0:0] CFG_MAX_SPEED = 1'b1;
    localparam logic CMD_GOAL = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] goal_a;
        logic [15:0] goal_b;
        logic [15:0] goal_c;
        logic        jump_now;
        logic [15:0] tick_period;
    } t_in_req;

    typedef struct packed {
        logic [15:0] position_a;
        logic [15:0] position_b;
        logic [15:0] position_c;
        logic [15:0] speed_a;
        logic [15:0] speed_b;
        logic [15:0] speed_c;
    } t_out_req;

    // controller -> datapath
    typedef struct packed {
        logic load_goals;
        logic start_tick;
        logic joint_start;
        logic sqrt_step;
        logic speed_update;
        logic joint_finish;
        logic capture_out;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic last_joint;
    } t_dp_status;

    function automatic logic [15:0] half_pi(input int frac);
        logic [63:0] v;
        v = (HALF_PI_Q30 + (64'd1 << (29 - frac))) >> (30 - frac);
        return v[15:0];
    endfunction
endpackage

>>> design/jmp_if.sv
// Valid/ready channel carrying one request payload.
`timescale 1ns / 1ps
interface jmp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> design/jmp_ctrl.sv
// Sequencer for goal loads and per-joint tick updates.
`timescale 1ns / 1ps
module jmp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jmp_pkg::t_dp_cmd    o_cmd,
    input  jmp_pkg::t_dp_status i_status
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_SQRT   = 6'b000100,
        S_SPEED  = 6'b001000,
        S_FINISH = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic acc;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in_cmd == jmp_pkg::CMD_TICK) begin
                        o_cmd.start_tick = 1'b1;
                        n_state = S_START;
                    end else begin
                        o_cmd.load_goals = 1'b1;
                    end
                end
            end
            S_START: begin
                o_cmd.joint_start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_done) n_state = S_SPEED;
            end
            S_SPEED: begin
                o_cmd.speed_update = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.joint_finish = 1'b1;
                n_state = i_status.last_joint ? S_OUT : S_START;
            end
            S_OUT: begin
                o_cmd.capture_out = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> design/jmp_datapath.sv
// Joint state, shared bit-serial square root and update arithmetic.
`timescale 1ns / 1ps
module jmp_datapath #(
    parameter int JOINT_COUNT = jmp_pkg::JOINT_COUNT_DEF,
    parameter int ANGLE_FRAC_BITS = jmp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  jmp_pkg::t_in_req           i_req,
    input  logic [jmp_pkg::ACCEL_W-1:0] i_max_accel,
    input  logic [jmp_pkg::SPEED_W-1:0] i_max_speed,
    input  jmp_pkg::t_dp_cmd           i_cmd,
    output jmp_pkg::t_dp_status        o_status,
    output jmp_pkg::t_out_req          o_out
);
    localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int SQ_ITERS = 31;
    localparam int SW = $clog2(SQ_ITERS + 1);
    localparam logic signed [33:0] PMAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] PMIN = -34'sh0_8000_0000;

    logic signed [15:0] r_goal [JOINT_COUNT];
    logic signed [31:0] r_pos  [JOINT_COUNT];
    logic signed [31:0] r_spd  [JOINT_COUNT];
    logic r_first;
    logic [JW-1:0] r_j;
    logic [15:0] r_dt;
    logic [35:0] r_lim;
    logic [45:0] r_cap;
    logic [61:0] r_rad;
    logic [32:0] r_rem;
    logic [30:0] r_root;
    logic [SW-1:0] r_cnt;
    logic r_neg, r_capped;
    jmp_pkg::t_out_req r_out;

    logic signed [15:0] goal_in [JOINT_COUNT];
    logic signed [33:0] err;
    logic [32:0] aerr;
    logic [52:0] prod;
    logic [34:0] rem_sh;
    logic [35:0] trial;
    logic signed [33:0] mag, target, dv, spd_sum, spd_new, pos_sum, pos_new;
    logic signed [36:0] slim;
    logic signed [49:0] mv;
    logic signed [33:0] mvs;

    always_comb begin
        for (int k = 0; k < JOINT_COUNT; k++) begin
            case (k)
                0: goal_in[k] = i_req.goal_a;
                1: goal_in[k] = i_req.goal_b;
                2: goal_in[k] = i_req.goal_c;
                default: goal_in[k] = '0;
            endcase
        end
    end

    assign err  = {{2{r_goal[r_j][15]}}, r_goal[r_j], 16'd0} - 34'(r_pos[r_j]);
    assign aerr = err[33] ? 33'(-err) : 33'(err);
    assign prod = 53'(aerr) * 53'(i_max_accel);
    // restoring sqrt of (prod << 16): two radicand bits in, one root bit out per cycle
    assign rem_sh = {r_rem, r_rad[61:60]};
    assign trial = {1'b0, rem_sh} - {3'd0, r_root, 2'b01};

    assign mag = r_capped ? 34'({i_max_speed, 16'd0}) : 34'(r_root);
    assign target = r_neg ? -mag : mag;
    assign slim = $signed({1'b0, r_lim});
    always_comb begin
        logic signed [36:0] d;
        d = 37'(target) - 37'(r_spd[r_j]);
        if (d > slim) d = slim;
        if (d < -slim) d = -slim;
        dv = 34'(d);
    end
    assign spd_sum = 34'(r_spd[r_j]) + dv;
    assign spd_new = (spd_sum > PMAX) ? PMAX : (spd_sum < PMIN) ? PMIN : spd_sum;
    assign mv  = 50'(r_spd[r_j]) * $signed({34'd0, r_dt});
    assign mvs = 34'(mv >>> 16);
    assign pos_sum = 34'(r_pos[r_j]) + mvs;
    assign pos_new = (pos_sum > PMAX) ? PMAX : (pos_sum < PMIN) ? PMIN : pos_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOINT_COUNT; k++) begin
                r_goal[k] <= (k == 1) ? $signed(jmp_pkg::half_pi(ANGLE_FRAC_BITS)) :
                             (k == 2) ? -$signed(jmp_pkg::half_pi(ANGLE_FRAC_BITS)) : 16'sd0;
                r_pos[k]  <= (k == 1) ? {jmp_pkg::half_pi(ANGLE_FRAC_BITS), 16'd0} :
                             (k == 2) ? {-jmp_pkg::half_pi(ANGLE_FRAC_BITS), 16'd0} : 32'd0;
                r_spd[k]  <= '0;
            end
            r_first <= 1'b1;
            r_j <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load_goals) begin
                for (int k = 0; k < JOINT_COUNT; k++) begin
                    r_goal[k] <= goal_in[k];
                    if (r_first || i_req.jump_now) r_pos[k] <= {goal_in[k], 16'd0};
                end
                r_first <= 1'b0;
            end
            if (i_cmd.start_tick) begin
                r_j <= '0;
                r_dt <= i_req.tick_period;
                r_lim <= 36'(i_max_accel) * 36'(i_req.tick_period);
                r_cap <= {30'(i_max_speed) * 30'(i_max_speed), 16'd0};
            end
            if (i_cmd.joint_start) begin
                r_neg <= err[33];
                r_capped <= prod >= 53'(r_cap);
                r_rad <= {prod[45:0], 16'd0};
                r_rem <= '0;
                r_root <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.sqrt_step) begin
                r_rad <= {r_rad[59:0], 2'b00};
                if (!trial[35]) begin
                    r_rem <= trial[32:0];
                    r_root <= {r_root[29:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[32:0];
                    r_root <= {r_root[29:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.speed_update) begin
                r_spd[r_j] <= spd_new[31:0];
            end
            if (i_cmd.joint_finish) begin
                r_pos[r_j] <= pos_new[31:0];
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.capture_out) begin
                r_out.position_a <= r_pos[0][31:16];
                r_out.speed_a    <= r_spd[0][31:16];
                r_out.position_b <= (JOINT_COUNT > 1) ? r_pos[JW'(1 % JOINT_COUNT)][31:16] : '0;
                r_out.speed_b    <= (JOINT_COUNT > 1) ? r_spd[JW'(1 % JOINT_COUNT)][31:16] : '0;
                r_out.position_c <= (JOINT_COUNT > 2) ? r_pos[JW'(2 % JOINT_COUNT)][31:16] : '0;
                r_out.speed_c    <= (JOINT_COUNT > 2) ? r_spd[JW'(2 % JOINT_COUNT)][31:16] : '0;
            end
        end
    end

    assign o_status.sqrt_done  = (r_cnt == SW'(SQ_ITERS - 1));
    assign o_status.last_joint = (32'(r_j) == JOINT_COUNT - 1);
    assign o_out = r_out;
endmodule

>>> design/joint_motion_profiler.sv
// Top level of the joint motion profiler.
`timescale 1ns / 1ps
// A goal request is taken and gives no result. A tick request steps through
// the joints in turn, each with a setup state, a shared bit-serial square root
// giving a 31-bit root (one root bit per cycle), a speed update state and a
// position update state; a final state registers the result. One request
// at a time: input is held off until the result has been taken.
module joint_motion_profiler #(
    parameter int JOINT_COUNT = jmp_pkg::JOINT_COUNT_DEF,
    parameter int ANGLE_FRAC_BITS = jmp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    jmp_if.sink                      in_if,
    jmp_if.source                    out_if,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [jmp_pkg::CFG_W-1:0] i_cfg_data
);
    logic [jmp_pkg::ACCEL_W-1:0] r_max_accel;
    logic [jmp_pkg::SPEED_W-1:0] r_max_speed;
    jmp_pkg::t_dp_cmd    cmd;
    jmp_pkg::t_dp_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_accel <= 20'd40960;
            r_max_speed <= 15'd8192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jmp_pkg::CFG_MAX_ACCEL: r_max_accel <= i_cfg_data;
                jmp_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_data[jmp_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    jmp_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_if.valid), .i_in_cmd(in_if.data.cmd), .o_in_ready(in_if.ready),
        .o_out_valid(out_if.valid), .i_out_ready(out_if.ready),
        .o_cmd(cmd), .i_status(status)
    );

    jmp_datapath #(.JOINT_COUNT(JOINT_COUNT), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_req(in_if.data),
        .i_max_accel(r_max_accel), .i_max_speed(r_max_speed),
        .i_cmd(cmd), .o_status(status), .o_out(out_if.data)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> !in_if.ready) else $error("request taken while result pending");
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd)) else $error("datapath commands overlap");
    a_out_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture_out |=> out_if.valid) else $error("result lost");
endmodule
